// ===== rtl/rte_pkg.sv =====
// Shared types and constants for the RTT timeout estimator.
// No dependencies; every other file of the block imports this package.
`default_nettype none

package rte_pkg;

    // Field and state widths
    localparam int KIND_W = 2;
    localparam int SEQ_W  = 10;
    localparam int TIME_W = 32;
    localparam int CFG_W  = 16;
    localparam int RTT_W  = 24;
    localparam int EST_W  = 27;
    localparam int RTO_W  = 30;

    // Item kinds
    localparam logic [KIND_W-1:0] KIND_SEND    = 2'd0;
    localparam logic [KIND_W-1:0] KIND_ACK     = 2'd1;
    localparam logic [KIND_W-1:0] KIND_RESTART = 2'd2;

    // Configuration register indexes
    localparam logic CFG_INITIAL_RTT = 1'b0;
    localparam logic CFG_INITIAL_RTO = 1'b1;

    // Reset values
    localparam logic [CFG_W-1:0] CFG_RESET  = 16'd250;
    localparam logic [EST_W-1:0] SRTT_RESET = 27'd2000;
    localparam logic [EST_W-1:0] VAR_RESET  = 27'd1000;
    localparam logic [RTT_W-1:0] RTT_MAX    = 24'hFF_FFFF;

    // Job queue between front and back
    localparam int QDEPTH = 2;
    localparam int QAW    = $clog2(QDEPTH);
    localparam int QCW    = $clog2(QDEPTH + 1);

    // Work handed to the estimator
    typedef enum logic [1:0] {
        OP_SAMPLE,
        OP_NOSAMPLE,
        OP_RESTART
    } t_op;

    typedef struct packed {
        t_op              op;
        logic [RTT_W-1:0] rtt;
    } t_job;

    // Configuration seen by the estimator
    typedef struct packed {
        logic [CFG_W-1:0] initial_rtt;
        logic [CFG_W-1:0] initial_rto;
    } t_cfg;

endpackage

`default_nettype wire

// ===== rtl/rtt_timeout_estimator_top.sv =====
// Top level of the RTT timeout estimator: configuration registers and wiring.
// Depends on rte_pkg, rte_front, rte_queue and rte_back.
//
//  channel  | handshake                    | payload
//  ---------+------------------------------+------------------------------------------
//  input    | i_in_valid / o_in_ready      | i_kind, i_seq, i_time_ms, i_no_sample
//  result   | o_out_valid / i_out_ready    | o_rto_eighths, o_rtt_ms, o_sample_used
//  config   | i_cfg_we (no wait)           | i_cfg_index, i_cfg_data
//
// Sends are taken one per cycle while o_in_ready is high, and only write the
// timestamp table. Acks and restarts pass the front-end stage (table read, RTT);
// the estimator reloads its state on a restart, fills the result register on an
// unsampled ack; a sampled ack runs error, update, RTO sum into the result register.
// A two-entry job queue lets the front end keep accepting while the estimator
// or a stalled result register is busy. Synchronous active-low reset; the
// timestamp table is not cleared.
`default_nettype none

module rtt_timeout_estimator_top #(
    parameter int SEQ_SLOTS = 1024
) (
    input  wire logic                       i_clk,
    input  wire logic                       i_rst_n,
    input  wire logic                       i_cfg_we,
    input  wire logic                       i_cfg_index,
    input  wire logic [rte_pkg::CFG_W-1:0]  i_cfg_data,
    input  wire logic                       i_in_valid,
    output logic                            o_in_ready,
    input  wire logic [rte_pkg::KIND_W-1:0] i_kind,
    input  wire logic [rte_pkg::SEQ_W-1:0]  i_seq,
    input  wire logic [rte_pkg::TIME_W-1:0] i_time_ms,
    input  wire logic                       i_no_sample,
    output logic                            o_out_valid,
    input  wire logic                       i_out_ready,
    output logic [rte_pkg::RTO_W-1:0]       o_rto_eighths,
    output logic [rte_pkg::RTT_W-1:0]       o_rtt_ms,
    output logic                            o_sample_used
);
    import rte_pkg::*;

    t_cfg r_cfg;
    t_job push_job;
    t_job head_job;
    logic push;
    logic full;
    logic pop;
    logic empty;

    // Configuration registers
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_cfg.initial_rtt <= CFG_RESET;
            r_cfg.initial_rto <= CFG_RESET;
        end else if (i_cfg_we) begin
            case (i_cfg_index)
                CFG_INITIAL_RTT: r_cfg.initial_rtt <= i_cfg_data;
                CFG_INITIAL_RTO: r_cfg.initial_rto <= i_cfg_data;
                default:         r_cfg <= r_cfg;
            endcase
        end
    end

    rte_front #(
        .SEQ_SLOTS (SEQ_SLOTS)
    ) u_front (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_in_valid  (i_in_valid),
        .o_in_ready  (o_in_ready),
        .i_kind      (i_kind),
        .i_seq       (i_seq),
        .i_time_ms   (i_time_ms),
        .i_no_sample (i_no_sample),
        .o_push      (push),
        .o_job       (push_job),
        .i_full      (full)
    );

    rte_queue u_queue (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_push  (push),
        .i_job   (push_job),
        .o_full  (full),
        .i_pop   (pop),
        .o_head  (head_job),
        .o_empty (empty)
    );

    rte_back u_back (
        .i_clk         (i_clk),
        .i_rst_n       (i_rst_n),
        .i_cfg         (r_cfg),
        .i_head        (head_job),
        .i_empty       (empty),
        .o_pop         (pop),
        .o_out_valid   (o_out_valid),
        .i_out_ready   (i_out_ready),
        .o_rto_eighths (o_rto_eighths),
        .o_rtt_ms      (o_rtt_ms),
        .o_sample_used (o_sample_used)
    );

endmodule

`default_nettype wire

// ===== rtl/rte_front.sv =====
// Front end: accepts items, keeps the send timestamp table, measures RTT.
// Depends on rte_pkg.
`default_nettype none

module rte_front #(
    parameter int SEQ_SLOTS = 1024
) (
    input  wire logic                      i_clk,
    input  wire logic                      i_rst_n,
    input  wire logic                      i_in_valid,
    output logic                           o_in_ready,
    input  wire logic [rte_pkg::KIND_W-1:0] i_kind,
    input  wire logic [rte_pkg::SEQ_W-1:0]  i_seq,
    input  wire logic [rte_pkg::TIME_W-1:0] i_time_ms,
    input  wire logic                      i_no_sample,
    output logic                           o_push,
    output rte_pkg::t_job                  o_job,
    input  wire logic                      i_full
);
    import rte_pkg::*;

    localparam int AW = (SEQ_SLOTS > 1) ? $clog2(SEQ_SLOTS) : 1;

    logic [TIME_W-1:0] r_mem [SEQ_SLOTS];
    logic [TIME_W-1:0] r_rd_data;
    logic [TIME_W-1:0] r_st_time;
    logic              r_st_valid;
    t_op               r_st_op;
    logic              n_st_valid;

    logic [SEQ_W-1:0]  rem;
    logic [AW-1:0]     slot;
    logic              accept;
    logic              is_job;
    t_op               op_in;
    logic [TIME_W-1:0] diff;

    // Reduce the sequence number to a table slot by constant long division
    always_comb begin
        rem = i_seq;
        for (int b = SEQ_W - 1; b >= 0; b--) begin
            if ((SEQ_SLOTS << b) < (1 << SEQ_W)) begin
                if ({22'd0, rem} >= (SEQ_SLOTS << b)) begin
                    rem = rem - SEQ_W'(SEQ_SLOTS << b);
                end
            end
        end
        slot = AW'(rem);
    end

    // Classify the incoming item
    always_comb begin
        is_job = (i_kind == KIND_ACK) || (i_kind == KIND_RESTART);
        if (i_kind == KIND_RESTART) begin
            op_in = OP_RESTART;
        end else if (i_no_sample) begin
            op_in = OP_NOSAMPLE;
        end else begin
            op_in = OP_SAMPLE;
        end
    end

    // The stage moves on when it is empty or its job goes into the queue
    assign o_push     = r_st_valid && !i_full;
    assign o_in_ready = !r_st_valid || !i_full;
    assign accept     = i_in_valid && o_in_ready;

    always_comb begin
        n_st_valid = r_st_valid;
        if (accept && is_job) begin
            n_st_valid = 1'b1;
        end else if (o_push) begin
            n_st_valid = 1'b0;
        end
    end

    // Timestamp table: write on send, registered read on ack or restart
    always_ff @(posedge i_clk) begin
        if (accept && (i_kind == KIND_SEND)) begin
            r_mem[slot] <= i_time_ms;
        end
        if (accept && is_job) begin
            r_rd_data <= r_mem[slot];
            r_st_time <= i_time_ms;
            r_st_op   <= op_in;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_st_valid <= 1'b0;
        end else begin
            r_st_valid <= n_st_valid;
        end
    end

    // Wrapping difference, saturated to the RTT field
    always_comb begin
        diff      = r_st_time - r_rd_data;
        o_job.op  = r_st_op;
        if (diff[TIME_W-1:RTT_W] != '0) begin
            o_job.rtt = RTT_MAX;
        end else begin
            o_job.rtt = diff[RTT_W-1:0];
        end
    end

endmodule

`default_nettype wire

// ===== rtl/rte_queue.sv =====
// Short job queue that decouples the front end from the estimator.
// Depends on rte_pkg.
`default_nettype none

module rte_queue (
    input  wire logic          i_clk,
    input  wire logic          i_rst_n,
    input  wire logic          i_push,
    input  rte_pkg::t_job      i_job,
    output logic               o_full,
    input  wire logic          i_pop,
    output rte_pkg::t_job      o_head,
    output logic               o_empty
);
    import rte_pkg::*;

    t_job             r_ent [QDEPTH];
    logic [QAW-1:0]   r_wr_ptr;
    logic [QAW-1:0]   r_rd_ptr;
    logic [QCW-1:0]   r_count;

    assign o_full  = (r_count == QCW'(QDEPTH));
    assign o_empty = (r_count == '0);
    assign o_head  = r_ent[r_rd_ptr];

    // Store the pushed job
    always_ff @(posedge i_clk) begin
        if (i_push) begin
            r_ent[r_wr_ptr] <= i_job;
        end
    end

    // Advance pointers and occupancy
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_wr_ptr <= '0;
            r_rd_ptr <= '0;
            r_count  <= '0;
        end else begin
            if (i_push) begin
                r_wr_ptr <= (r_wr_ptr == QAW'(QDEPTH - 1)) ? '0 : r_wr_ptr + 1'b1;
            end
            if (i_pop) begin
                r_rd_ptr <= (r_rd_ptr == QAW'(QDEPTH - 1)) ? '0 : r_rd_ptr + 1'b1;
            end
            case ({i_push, i_pop})
                2'b10:   r_count <= r_count + 1'b1;
                2'b01:   r_count <= r_count - 1'b1;
                default: r_count <= r_count;
            endcase
        end
    end

    a_no_overflow: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        !(i_push && o_full))
        else $error("job pushed into a full queue");

    a_no_underflow: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        !(i_pop && o_empty))
        else $error("job popped from an empty queue");

endmodule

`default_nettype wire

// ===== rtl/rte_back.sv =====
// Back end: smoothed RTT and variance state, update sequencer and result register.
// Depends on rte_pkg.
`default_nettype none

module rte_back (
    input  wire logic                     i_clk,
    input  wire logic                     i_rst_n,
    input  rte_pkg::t_cfg                 i_cfg,
    input  rte_pkg::t_job                 i_head,
    input  wire logic                     i_empty,
    output logic                          o_pop,
    output logic                          o_out_valid,
    input  wire logic                     i_out_ready,
    output logic [rte_pkg::RTO_W-1:0]     o_rto_eighths,
    output logic [rte_pkg::RTT_W-1:0]     o_rtt_ms,
    output logic                          o_sample_used
);
    import rte_pkg::*;

    typedef enum logic [1:0] {
        S_IDLE,
        S_UPD,
        S_OUT
    } t_state;

    t_state             r_state;
    logic [EST_W-1:0]   r_srtt;
    logic [EST_W-1:0]   r_var;
    logic signed [27:0] r_err;
    logic [RTT_W-1:0]   r_rtt;
    logic               r_used;
    logic               r_out_valid;
    logic [RTO_W-1:0]   r_out_rto;
    logic [RTT_W-1:0]   r_out_rtt;
    logic               r_out_used;

    logic signed [27:0] err_new;
    logic signed [27:0] err_sh;
    logic [27:0]        mag;
    logic signed [28:0] s_sum;
    logic signed [28:0] d_diff;
    logic signed [28:0] d_sh;
    logic signed [28:0] v_sum;
    logic [RTO_W-1:0]   rto_sum;
    logic               out_free;
    logic               load_out;

    assign o_pop         = (r_state == S_IDLE) && !i_empty;
    assign out_free      = !r_out_valid || i_out_ready;
    assign load_out      = (r_state == S_OUT) && out_free;
    assign o_out_valid   = r_out_valid;
    assign o_rto_eighths = r_out_rto;
    assign o_rtt_ms      = r_out_rtt;
    assign o_sample_used = r_out_used;

    // Error of the new sample against the smoothed RTT
    assign err_new = $signed({1'b0, i_head.rtt, 3'b000}) - $signed({1'b0, r_srtt});

    // Smoothed RTT and variance updates, arithmetic shifts
    always_comb begin
        err_sh  = r_err >>> 3;
        s_sum   = $signed({2'b00, r_srtt}) + $signed({err_sh[27], err_sh});
        mag     = r_err[27] ? 28'(-r_err) : 28'(r_err);
        d_diff  = $signed({1'b0, mag}) - $signed({2'b00, r_var});
        d_sh    = d_diff >>> 2;
        v_sum   = $signed({2'b00, r_var}) + d_sh;
        rto_sum = {3'b000, r_srtt} + {1'b0, r_var, 2'b00};
    end

    // Sequencer, estimator state and result register
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state     <= S_IDLE;
            r_srtt      <= SRTT_RESET;
            r_var       <= VAR_RESET;
            r_out_valid <= 1'b0;
        end else begin
            // Load a new word, or drop the one taken by the receiver
            if (load_out) begin
                r_out_valid <= 1'b1;
            end else if (i_out_ready) begin
                r_out_valid <= 1'b0;
            end
            case (r_state)
                S_IDLE: begin
                    if (o_pop) begin
                        case (i_head.op)
                            OP_RESTART: begin
                                r_srtt <= EST_W'({i_cfg.initial_rtt, 3'b000});
                                r_var  <= EST_W'({i_cfg.initial_rtt, 2'b00});
                            end
                            OP_NOSAMPLE: begin
                                r_used  <= 1'b0;
                                r_rtt   <= '0;
                                r_state <= S_OUT;
                            end
                            OP_SAMPLE: begin
                                r_used  <= 1'b1;
                                r_rtt   <= i_head.rtt;
                                r_err   <= err_new;
                                r_state <= S_UPD;
                            end
                            default: r_state <= S_IDLE;
                        endcase
                    end
                end
                S_UPD: begin
                    r_srtt  <= s_sum[EST_W-1:0];
                    r_var   <= v_sum[EST_W-1:0];
                    r_state <= S_OUT;
                end
                S_OUT: begin
                    if (load_out) begin
                        r_out_rto   <= r_used ? rto_sum
                                              : RTO_W'({i_cfg.initial_rto, 3'b000});
                        r_out_rtt   <= r_rtt;
                        r_out_used  <= r_used;
                        r_state     <= S_IDLE;
                    end
                end
                default: r_state <= S_IDLE;
            endcase
        end
    end

    a_nosample_zero_rtt: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_out_valid && !r_out_used) |-> (r_out_rtt == '0))
        else $error("result without sample carries a nonzero RTT");

    a_sample_updates: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_pop && (i_head.op == OP_SAMPLE)) |=> (r_state == S_UPD))
        else $error("sampled ack did not enter the update step");

    a_hold_result: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        ((r_state == S_OUT) && !out_free) |=> (r_state == S_OUT))
        else $error("pending result dropped while output stalled");

    a_restart_no_result: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_pop && (i_head.op == OP_RESTART) && !r_out_valid) |=> !r_out_valid)
        else $error("restart produced a result");

endmodule

`default_nettype wire

// ===== sim/rtt_timeout_estimator_top_tb.sv =====
`timescale 1ns / 1ps
// Self-checking testbench for rtt_timeout_estimator_top: directed and random words,
// predicted timeouts compared field by field. Depends on rte_pkg and the RTL of the block.
module rtt_timeout_estimator_top_tb;
    import rte_pkg::*;

    localparam int     SEQ_SLOTS   = 1024;
    localparam int     DRAIN_WAIT  = 16;
    localparam int     HOLD_CYCLES = 300;
    localparam int     MAX_PRINTED = 20;
    localparam longint LIMIT_NS    = 4_000_000;

    // Kind code the block leaves unused
    localparam logic [KIND_W-1:0] KIND_UNUSED = 2'd3;

    typedef struct {
        logic [RTO_W-1:0] rto;
        logic [RTT_W-1:0] rtt;
        logic             used;
    } t_rto_result;

    logic                i_clk       = 1'b0;
    logic                i_rst_n     = 1'b0;
    logic                i_cfg_we    = 1'b0;
    logic                i_cfg_index = CFG_INITIAL_RTT;
    logic [CFG_W-1:0]    i_cfg_data  = '0;
    logic                i_in_valid  = 1'b0;
    logic                o_in_ready;
    logic [KIND_W-1:0]   i_kind      = KIND_SEND;
    logic [SEQ_W-1:0]    i_seq       = '0;
    logic [TIME_W-1:0]   i_time_ms   = '0;
    logic                i_no_sample = 1'b0;
    logic                o_out_valid;
    logic                i_out_ready = 1'b0;
    logic [RTO_W-1:0]    o_rto_eighths;
    logic [RTT_W-1:0]    o_rtt_ms;
    logic                o_sample_used;

    // Estimator copy kept alongside the block
    logic [EST_W-1:0]    est_srtt     = SRTT_RESET;
    logic [EST_W-1:0]    est_var      = VAR_RESET;
    logic [CFG_W-1:0]    cfg_init_rtt = CFG_RESET;
    logic [CFG_W-1:0]    cfg_init_rto = CFG_RESET;
    logic [TIME_W-1:0]   stamp_table [0:SEQ_SLOTS-1];
    bit                  stamp_written [0:SEQ_SLOTS-1];
    t_rto_result         rto_expected [$];

    logic [TIME_W-1:0]   clock_ms;
    int                  send_idle_pct  = 0;
    int                  recv_stall_pct = 0;
    int                  out_hold_req   = 0;
    int                  out_hold_seen  = 0;
    int                  out_hold_left  = 0;
    int                  items_sent     = 0;
    int                  results_checked = 0;
    int                  config_writes  = 0;
    int                  mismatches     = 0;

    rtt_timeout_estimator_top dut (
        .i_clk         (i_clk),
        .i_rst_n       (i_rst_n),
        .i_cfg_we      (i_cfg_we),
        .i_cfg_index   (i_cfg_index),
        .i_cfg_data    (i_cfg_data),
        .i_in_valid    (i_in_valid),
        .o_in_ready    (o_in_ready),
        .i_kind        (i_kind),
        .i_seq         (i_seq),
        .i_time_ms     (i_time_ms),
        .i_no_sample   (i_no_sample),
        .o_out_valid   (o_out_valid),
        .i_out_ready   (i_out_ready),
        .o_rto_eighths (o_rto_eighths),
        .o_rtt_ms      (o_rtt_ms),
        .o_sample_used (o_sample_used)
    );

    always #4 i_clk = ~i_clk;

    // Print the first few mismatches, count them all
    task automatic report_mismatch(input string msg);
        if (mismatches < MAX_PRINTED) begin
            $display("[%0t] mismatch: %s", $realtime, msg);
        end
        mismatches++;
    endtask

    // Advance the estimator copy by one accepted word; queue the timeout it yields
    task automatic predict_timeout(input logic [KIND_W-1:0] kind, input logic [SEQ_W-1:0] seq,
                                   input logic [TIME_W-1:0] stamp, input logic no_samp);
        logic [TIME_W-1:0] span;
        logic [RTT_W-1:0]  rtt;
        longint            rtt_l, cur_srtt, cur_var, err, mag, nsrtt, nvar;
        t_rto_result       want;
        case (kind)
            KIND_SEND: begin
                stamp_table[seq]   = stamp;
                stamp_written[seq] = 1'b1;
            end
            KIND_RESTART: begin
                est_srtt = {8'b0, cfg_init_rtt, 3'b0};
                est_var  = {9'b0, cfg_init_rtt, 2'b0};
            end
            KIND_ACK: begin
                if (no_samp) begin
                    want.rto  = {11'b0, cfg_init_rto, 3'b0};
                    want.rtt  = '0;
                    want.used = 1'b0;
                end else begin
                    span     = stamp - stamp_table[seq];
                    rtt      = (span > {8'b0, RTT_MAX}) ? RTT_MAX : span[RTT_W-1:0];
                    rtt_l    = longint'(rtt);
                    cur_srtt = longint'(est_srtt);
                    cur_var  = longint'(est_var);
                    err      = rtt_l * 8 - cur_srtt;
                    mag      = (err < 0) ? -err : err;
                    // arithmetic shifts floor toward minus infinity
                    nsrtt    = cur_srtt + (err >>> 3);
                    nvar     = cur_var + ((mag - cur_var) >>> 2);
                    est_srtt = nsrtt[EST_W-1:0];
                    est_var  = nvar[EST_W-1:0];
                    want.rto  = {3'b0, est_srtt} + {1'b0, est_var, 2'b0};
                    want.rtt  = rtt;
                    want.used = 1'b1;
                end
                rto_expected.push_back(want);
            end
            default: begin
            end
        endcase
    endtask

    // Offer one word after a random idle gap; leave valid high once accepted
    task automatic send_word(input logic [KIND_W-1:0] kind, input logic [SEQ_W-1:0] seq,
                             input logic [TIME_W-1:0] stamp, input logic no_samp);
        while ($urandom_range(1, 100) <= send_idle_pct) begin
            i_in_valid <= 1'b0;
            @(posedge i_clk);
        end
        i_in_valid  <= 1'b1;
        i_kind      <= kind;
        i_seq       <= seq;
        i_time_ms   <= stamp;
        i_no_sample <= no_samp;
        @(posedge i_clk);
        while (!o_in_ready) @(posedge i_clk);
        predict_timeout(kind, seq, stamp, no_samp);
        if (kind != KIND_UNUSED) items_sent++;
    endtask

    // Drop valid, wait for every queued timeout, then let the block settle
    task automatic wait_results_drained();
        i_in_valid <= 1'b0;
        while (rto_expected.size() != 0) @(posedge i_clk);
        repeat (DRAIN_WAIT) @(posedge i_clk);
    endtask

    // Write both registers back to back; only called with the block idle
    task automatic write_timeout_regs(input logic [CFG_W-1:0] rtt_val,
                                      input logic [CFG_W-1:0] rto_val);
        i_cfg_we    <= 1'b1;
        i_cfg_index <= CFG_INITIAL_RTT;
        i_cfg_data  <= rtt_val;
        @(posedge i_clk);
        i_cfg_index <= CFG_INITIAL_RTO;
        i_cfg_data  <= rto_val;
        @(posedge i_clk);
        i_cfg_we     <= 1'b0;
        cfg_init_rtt  = rtt_val;
        cfg_init_rto  = rto_val;
        config_writes += 2;
    endtask

    // Mostly short round trips, now and then long, saturating or wrapping ones
    function automatic logic [TIME_W-1:0] next_gap();
        int pick;
        pick = $urandom_range(1, 100);
        if (pick <= 70) return $urandom_range(0, 400);
        if (pick <= 90) return $urandom_range(0, 20000);
        if (pick <= 97) return $urandom_range(0, 32'h0100_0400);
        return $urandom();
    endfunction

    // Interleaved send/ack exchanges with random content, plus some noise
    task automatic run_traffic(input int words);
        logic [SEQ_W-1:0] pending [$];
        logic [SEQ_W-1:0] slot;
        int               pick;
        int               idx;
        int               target;
        target = items_sent + words;
        while (items_sent < target) begin
            pick     = $urandom_range(1, 100);
            clock_ms = clock_ms + next_gap();
            if (pending.size() == 0 || (pick <= 42 && pending.size() < 16)) begin
                slot = SEQ_W'($urandom_range(0, SEQ_SLOTS - 1));
                send_word(KIND_SEND, slot, clock_ms, 1'($urandom_range(0, 1)));
                pending.push_back(slot);
            end else if (pick <= 84) begin
                idx  = $urandom_range(0, pending.size() - 1);
                slot = pending[idx];
                pending.delete(idx);
                send_word(KIND_ACK, slot, clock_ms, 1'b0);
            end else if (pick <= 90) begin
                send_word(KIND_ACK, pending[0], $urandom(), 1'b1);
            end else if (pick <= 94) begin
                send_word(KIND_RESTART, SEQ_W'($urandom_range(0, SEQ_SLOTS - 1)), $urandom(),
                          1'($urandom_range(0, 1)));
            end else if (pick <= 97) begin
                // late ack against whatever stamp the slot still holds
                slot = SEQ_W'($urandom_range(0, SEQ_SLOTS - 1));
                if (!stamp_written[slot]) slot = pending[0];
                send_word(KIND_ACK, slot, clock_ms, 1'b0);
            end else begin
                send_word(KIND_UNUSED, SEQ_W'($urandom_range(0, SEQ_SLOTS - 1)), $urandom(),
                          1'($urandom_range(0, 1)));
            end
        end
    endtask

    // Estimator state and registers straight out of reset
    task automatic test_reset_defaults();
        send_word(KIND_SEND, 10'd0, 32'd1000, 1'b0);
        send_word(KIND_ACK, 10'd0, 32'd1000, 1'b1);
        send_word(KIND_ACK, 10'd0, 32'd1100, 1'b0);
    endtask

    // Field extremes, wrap, saturation, zero RTT, ignored bits and the unused kind
    task automatic test_field_extremes();
        send_word(KIND_SEND, 10'd1023, 32'hFFFF_FFF0, 1'b0);
        send_word(KIND_ACK, 10'd1023, 32'h0000_0010, 1'b0);
        send_word(KIND_SEND, 10'd0, 32'h0000_0000, 1'b1);
        send_word(KIND_ACK, 10'd0, 32'hFFFF_FFFF, 1'b0);
        send_word(KIND_SEND, 10'd1, 32'd5, 1'b0);
        send_word(KIND_ACK, 10'd1, 32'd5, 1'b0);
        send_word(KIND_SEND, 10'd2, 32'd0, 1'b0);
        send_word(KIND_ACK, 10'd2, 32'h00FF_FFFF, 1'b0);
        send_word(KIND_ACK, 10'd2, 32'h0100_0000, 1'b0);
        send_word(KIND_UNUSED, 10'd1023, 32'hFFFF_FFFF, 1'b1);
        send_word(KIND_RESTART, 10'd1023, 32'hFFFF_FFFF, 1'b1);
        send_word(KIND_ACK, 10'd1, 32'hFFFF_FFFF, 1'b1);
        send_word(KIND_ACK, 10'd1023, 32'h0000_0012, 1'b0);
    endtask

    // Smallest and largest register values through restart and both ack forms
    task automatic test_config_extremes();
        wait_results_drained();
        write_timeout_regs(16'd1, 16'd1);
        send_word(KIND_RESTART, 10'd0, 32'd0, 1'b0);
        send_word(KIND_ACK, 10'd0, 32'd0, 1'b1);
        send_word(KIND_SEND, 10'd3, 32'd777, 1'b0);
        send_word(KIND_ACK, 10'd3, 32'd777, 1'b0);
        wait_results_drained();
        write_timeout_regs(16'hFFFF, 16'hFFFF);
        send_word(KIND_RESTART, 10'd0, 32'd0, 1'b0);
        send_word(KIND_ACK, 10'd0, 32'd0, 1'b1);
        send_word(KIND_SEND, 10'd4, 32'd0, 1'b0);
        send_word(KIND_ACK, 10'd4, 32'h00FF_FFFF, 1'b0);
    endtask

    // Random traffic under four idling mixes, each with its own register setting
    task automatic test_random_mix();
        int idle_mix  [4];
        int stall_mix [4];
        idle_mix  = '{0, 63, 0, 12};
        stall_mix = '{0, 0, 63, 12};
        for (int ph = 0; ph < 4; ph++) begin
            wait_results_drained();
            case (ph)
                0: write_timeout_regs(CFG_W'($urandom_range(1, 600)),
                                      CFG_W'($urandom_range(1, 600)));
                1: write_timeout_regs(16'hFFFF, 16'd1);
                2: write_timeout_regs(16'd1, 16'hFFFF);
                default: write_timeout_regs(CFG_W'($urandom_range(1, 65535)),
                                            CFG_W'($urandom_range(1, 65535)));
            endcase
            send_idle_pct   = idle_mix[ph];
            recv_stall_pct <= stall_mix[ph];
            run_traffic(210);
            // pause the sender until the output side has caught up
            wait_results_drained();
            run_traffic(210);
        end
        send_idle_pct   = 0;
        recv_stall_pct <= 0;
    endtask

    // Hold the output off for a long stretch while words keep coming
    task automatic test_output_holdoff();
        logic [SEQ_W-1:0] slot;
        wait_results_drained();
        out_hold_req <= out_hold_req + 1;
        for (int n = 0; n < 30; n++) begin
            slot     = SEQ_W'($urandom_range(0, SEQ_SLOTS - 1));
            clock_ms = clock_ms + next_gap();
            send_word(KIND_SEND, slot, clock_ms, 1'b0);
            clock_ms = clock_ms + next_gap();
            send_word(KIND_ACK, slot, clock_ms, 1'b0);
        end
        wait_results_drained();
    endtask

    // Output ready: long hold-off on request, else random stalls
    always @(posedge i_clk) begin
        if (out_hold_left != 0) begin
            out_hold_left <= out_hold_left - 1;
            i_out_ready   <= 1'b0;
        end else if (out_hold_seen != out_hold_req) begin
            out_hold_seen <= out_hold_req;
            out_hold_left <= HOLD_CYCLES;
            i_out_ready   <= 1'b0;
        end else begin
            i_out_ready <= ($urandom_range(1, 100) > recv_stall_pct);
        end
    end

    // Compare each accepted result with the oldest queued timeout
    always @(posedge i_clk) begin : check_results
        t_rto_result want;
        if (i_rst_n && o_out_valid && i_out_ready) begin
            if (rto_expected.size() == 0) begin
                report_mismatch("result word with nothing expected");
            end else begin
                want = rto_expected.pop_front();
                results_checked++;
                if (o_rto_eighths !== want.rto)
                    report_mismatch($sformatf("rto_eighths got %0d want %0d",
                                              o_rto_eighths, want.rto));
                if (o_rtt_ms !== want.rtt)
                    report_mismatch($sformatf("rtt_ms got %0d want %0d", o_rtt_ms, want.rtt));
                if (o_sample_used !== want.used)
                    report_mismatch($sformatf("sample_used got %0b want %0b",
                                              o_sample_used, want.used));
            end
        end
    end

    // Hard stop if the run hangs
    initial begin
        #(LIMIT_NS);
        $display("FAIL");
        $finish;
    end

    initial begin
        clock_ms = $urandom();
        repeat (9) @(posedge i_clk);
        i_rst_n <= 1'b1;
        @(posedge i_clk);

        test_reset_defaults();
        test_field_extremes();
        test_config_extremes();
        test_output_holdoff();
        test_random_mix();
        wait_results_drained();

        $display("Covered %0d words (sends, acks, restarts), %0d timeouts checked,",
                 items_sent, results_checked);
        $display("%0d register writes, four idling mixes and a %0d-cycle output hold-off; %0d mismatches.",
                 config_writes, HOLD_CYCLES, mismatches);
        if (mismatches == 0 && rto_expected.size() == 0) begin
            $display("PASS");
        end else begin
            $display("FAIL");
        end
        $finish;
    end

endmodule

// ===== sim.f =====
rtl/rte_pkg.sv
rtl/rte_front.sv
rtl/rte_queue.sv
rtl/rte_back.sv
rtl/rtt_timeout_estimator_top.sv
sim/rtt_timeout_estimator_top_tb.sv
